>>> sv/oqr_pkg.sv
`default_nettype none

package oqr_pkg;

    localparam int DEPTH = 16;
    localparam int TAG_W = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic             shift_in;
        logic             shift_out;
        logic             ordered;
        logic             match_en;
        logic [7:0]       key;
        logic [TAG_W-1:0] tag;
        logic [CNT_W-1:0] count;
    } cell_ctl_t;

    // prefix flags rippling from the front cell towards the tail
    typedef struct packed {
        logic ins_seen;
        logic rm_seen;
    } cell_link_t;

endpackage

`default_nettype wire

>>> sv/oqr_cell.sv
`default_nettype none

module oqr_cell (
    input  wire logic                     clk,
    input  wire oqr_pkg::cell_ctl_t       ctl,
    input  wire logic [oqr_pkg::IDX_W-1:0] idx,
    input  wire logic [7:0]               prev_key,
    input  wire logic [oqr_pkg::TAG_W-1:0] prev_tag,
    input  wire logic [7:0]               next_key,
    input  wire logic [oqr_pkg::TAG_W-1:0] next_tag,
    input  wire oqr_pkg::cell_link_t      link_in,
    output oqr_pkg::cell_link_t           link_out,
    output logic [7:0]                    key,
    output logic [oqr_pkg::TAG_W-1:0]     tag
);
    import oqr_pkg::*;

    logic [7:0]       key_reg;
    logic [7:0]       key_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    logic             occ;
    logic             stop;
    logic             match;

    always_comb
    begin
        occ   = CNT_W'(idx) < ctl.count;
        // insert point: first free cell, or first key not above the new one
        stop  = !occ || (ctl.ordered && (key_reg <= ctl.key));
        match = ctl.match_en && occ && (key_reg == ctl.key);
        link_out.ins_seen = link_in.ins_seen || stop;
        link_out.rm_seen  = link_in.rm_seen || match;

        key_next = key_reg;
        tag_next = tag_reg;
        if (ctl.shift_in)
        begin
            if (link_in.ins_seen)
            begin
                key_next = prev_key;
                tag_next = prev_tag;
            end
            else if (stop)
            begin
                key_next = ctl.key;
                tag_next = ctl.tag;
            end
        end
        else if (ctl.shift_out && link_out.rm_seen)
        begin
            key_next = next_key;
            tag_next = next_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

>>> sv/ordered_queue_remove_by_key_top.sv
// ordered queue with remove by key, kept as a row of shift cells
// s_axis carries one command word: append, ordered insert, pop front,
// remove by key or clear, with the key and tag of the entry
// m_axis returns one result word per command: ok flag, popped key and tag,
// entry count and empty flag after the command
// every cell compares its key against the command in the same cycle; the
// result is registered and shows on m_axis in the cycle after s_axis
// accepts it
// a new command is taken in every cycle while m_axis is free or being read,
// one word per cycle sustained
// when the receiver stalls, the result word holds and s_axis_tready drops
// until it is taken; the queue does not change meanwhile
// reset empties the queue (count zero) and drops any pending result; cell
// contents are not cleared and only occupied cells are ever read
`default_nettype none

module ordered_queue_remove_by_key_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // op[2:0], key[10:3], tag[26:11]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata   // ok[0], out_key[8:1], out_tag[24:9],
                                            // count[29:25], empty_res[30]
);
    import oqr_pkg::*;

    logic [2:0]       op;
    logic [7:0]       in_key;
    logic [15:0]      in_tag;
    logic             accept;
    logic             full;
    logic             nonempty;
    logic             found;
    logic             ok;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [31:0]      out_data_reg;
    logic [31:0]      out_data_next;
    logic [7:0]       pop_key;
    logic [15:0]      pop_tag;
    cell_ctl_t        ctl;

    logic [7:0]       cell_key [DEPTH];
    logic [TAG_W-1:0] cell_tag [DEPTH];
    cell_link_t       link [DEPTH+1];

    assign op     = s_axis_tdata[2:0];
    assign in_key = s_axis_tdata[10:3];
    assign in_tag = s_axis_tdata[26:11];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign full          = count_reg == CNT_W'(DEPTH);
    assign nonempty      = count_reg != '0;
    assign found         = link[DEPTH].rm_seen;

    assign link[0].ins_seen = 1'b0;
    assign link[0].rm_seen  = op == OP_POP;

    always_comb
    begin
        ctl.key       = in_key;
        ctl.tag       = TAG_W'(in_tag);
        ctl.count     = count_reg;
        ctl.ordered   = op == OP_INSERT;
        ctl.match_en  = op == OP_REMOVE;
        ctl.shift_in  = accept && !full && (op == OP_APPEND || op == OP_INSERT);
        ctl.shift_out = accept && ((op == OP_REMOVE && found) || (op == OP_POP && nonempty));
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0]       prev_key;
        logic [TAG_W-1:0] prev_tag;
        logic [7:0]       next_key;
        logic [TAG_W-1:0] next_tag;

        if (i == 0)
        begin : g_front
            assign prev_key = in_key;
            assign prev_tag = TAG_W'(in_tag);
        end
        else
        begin : g_mid
            assign prev_key = cell_key[i-1];
            assign prev_tag = cell_tag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign next_key = cell_key[i];
            assign next_tag = cell_tag[i];
        end
        else
        begin : g_body
            assign next_key = cell_key[i+1];
            assign next_tag = cell_tag[i+1];
        end

        oqr_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .idx      (IDX_W'(i)),
            .prev_key (prev_key),
            .prev_tag (prev_tag),
            .next_key (next_key),
            .next_tag (next_tag),
            .link_in  (link[i]),
            .link_out (link[i+1]),
            .key      (cell_key[i]),
            .tag      (cell_tag[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        ok         = 1'b0;
        pop_key    = '0;
        pop_tag    = '0;
        unique case (op)
            OP_APPEND, OP_INSERT:
            begin
                ok = !full;
                if (!full)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                ok = nonempty;
                if (nonempty)
                begin
                    count_next = count_reg - CNT_W'(1);
                    pop_key    = cell_key[0];
                    pop_tag    = 16'(cell_tag[0]);
                end
            end
            OP_REMOVE:
            begin
                ok = found;
                if (found)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_CLEAR:
            begin
                ok         = 1'b1;
                count_next = '0;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        out_data_next = {1'b0, count_next == '0, 5'(count_next), pop_tag, pop_key, ok};
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire
